[sv/signed_binary_to_decimal_ascii_defines.svh]
// assertion macros used by the checker file
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// antecedent holds, consequent must hold in the next cycle
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbda check failed");

// antecedent holds, consequent must hold in the same cycle
`define SBDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbda check failed");

`endif

[sv/sbda_pkg.sv]
// shared types and constants for the signed binary to decimal ascii converter
package sbda_pkg;

  localparam int VALUE_W    = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // operation applied to every cell of the digit row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

endpackage

[sv/sbda_cell.sv]
// one bcd digit cell of the shift-add-3 row
module sbda_cell (
  input  logic             clk,
  input  sbda_pkg::cell_op_t op,
  input  logic             bit_in,
  input  logic [3:0]       digit_in,
  output logic             bit_out,
  output logic [3:0]       digit_q
);
  import sbda_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // add 3 when the digit would overflow on doubling
  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out = adj[3];
  assign digit_q = digit_r;

  // next digit per row operation
  always_comb begin
    unique case (op)
      CELL_CLEAR:  digit_nxt = 4'd0;
      CELL_DABBLE: digit_nxt = {adj[2:0], bit_in};
      CELL_SHIFT:  digit_nxt = digit_in;
      default:     digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

[sv/signed_binary_to_decimal_ascii.sv]
// top level: signed 64-bit integer to decimal ascii characters
// each accepted value is shifted in bit by bit, msb first, through a row of 20 bcd cells
// (shift-add-3), then leading zero digits are dropped one per cycle, then one character
// per cycle leaves while the receiver is ready (sign first); the next value is taken
// once the last character is registered, while that character still waits
// reset (rst_n low, synchronous) clears the state machine and output valid; digits are not reset
module signed_binary_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import sbda_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_W-1:0]     mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  cell_op_t               cell_op;
  logic [NUM_DIGITS-1:0]  bit_chain;
  logic [3:0]             dig_chain [NUM_DIGITS];
  logic [3:0]             top_digit;
  logic                   in_acc;
  logic                   out_free;

  assign in_ready      = (state_r == S_IDLE);
  assign in_acc        = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign top_digit     = dig_chain[NUM_DIGITS-1];
  assign bit_chain[0]  = mag_r[VALUE_W-1];

  // row of bcd cells, lowest digit at index 0
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [3:0] d_in;
    if (i == 0) begin : g_first
      assign d_in = 4'd0;
    end else begin : g_rest
      assign d_in = dig_chain[i-1];
    end
    if (i == NUM_DIGITS - 1) begin : g_top
      sbda_cell u_cell (
        .clk     (clk),
        .op      (cell_op),
        .bit_in  (bit_chain[i]),
        .digit_in(d_in),
        .bit_out (),
        .digit_q (dig_chain[i])
      );
    end else begin : g_mid
      sbda_cell u_cell (
        .clk     (clk),
        .op      (cell_op),
        .bit_in  (bit_chain[i]),
        .digit_in(d_in),
        .bit_out (bit_chain[i+1]),
        .digit_q (dig_chain[i])
      );
    end
  end

  // control and output register next values
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    cell_op       = CELL_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          neg_nxt     = in_value[VALUE_W-1];
          mag_nxt     = in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                            : VALUE_W'(in_value);
          bit_cnt_nxt = '0;
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          cell_op     = CELL_CLEAR;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        cell_op     = CELL_DABBLE;
        mag_nxt     = {mag_r[VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, always keep one digit
        if (top_digit == 4'd0 && dig_cnt_r > DIG_CNT_W'(1)) begin
          cell_op     = CELL_SHIFT;
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_char_nxt = CH_MINUS;
            out_last_nxt = 1'b0;
            neg_nxt      = 1'b0;
          end else begin
            out_char_nxt = CH_ZERO | {4'd0, top_digit};
            out_last_nxt = (dig_cnt_r == DIG_CNT_W'(1));
            cell_op      = CELL_SHIFT;
            dig_cnt_nxt  = dig_cnt_r - 1'b1;
            if (dig_cnt_r == DIG_CNT_W'(1)) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[sv/sbda_checker.sv]
// port-level checks for the converter, bound to the top level
`include "signed_binary_to_decimal_ascii_defines.svh"

module sbda_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last
);
  import sbda_pkg::*;

  logic       out_stall;
  logic [8:0] out_word;
  logic       char_ok;

  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_character, out_last};
  assign char_ok   = (out_character == CH_MINUS && !out_last) ||
                     (out_character >= CH_ZERO && out_character <= (CH_ZERO + 8'd9));

  // a stalled character holds
  `SBDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

  // an accepted request keeps the converter busy next cycle
  `SBDA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)

  // only a final character may wait while a new request is taken
  `SBDA_ASSERT_SAME(a_ready_only_after_last, clk, rst_n, out_valid && !out_last, !in_ready)

  // characters are a minus sign or a decimal digit
  `SBDA_ASSERT_SAME(a_char_legal, clk, rst_n, out_valid, char_ok)

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_character(out_character),
  .out_last     (out_last)
);

[bench/tb_signed_binary_to_decimal_ascii.sv]
// testbench for the signed 64-bit to decimal ascii converter
`timescale 1ns / 100ps

module tb_signed_binary_to_decimal_ascii;
  import sbda_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 120;
  localparam int CALM_ITEMS     = 30;
  localparam int RANDOM_ITEMS   = 158;

  // one conversion request and one expected output character
  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 drain_first;
    bit                 gappy;
  } conv_req_t;

  typedef struct {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [VALUE_W-1:0]   in_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_character;
  logic                        out_last;

  conv_req_t  req_q[$];
  text_char_t text_q[$];

  int owed_r       = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  bit all_sent     = 1'b0;
  bit calm         = 1'b0;
  int gap_left     = 0;
  int stall_left   = 0;
  bit stall_mode   = 1'b1;

  signed_binary_to_decimal_ascii u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // queue the decimal text of one value, sign first, last flag on the final digit
  function automatic void push_decimal_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rem;
    logic [7:0]         digs[$];
    text_char_t         tc;
    mag = v[VALUE_W-1] ? (64'd0 - v) : v;
    do begin
      rem = mag % 64'd10;
      digs.push_front(CH_ZERO + rem[7:0]);
      mag = mag / 64'd10;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      tc.character = CH_MINUS;
      tc.last      = 1'b0;
      text_q.push_back(tc);
    end
    foreach (digs[i]) begin
      tc.character = digs[i];
      tc.last      = (i == digs.size() - 1);
      text_q.push_back(tc);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    conv_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_value <= '0;
    end else if (!(in_valid && !in_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() == 0) begin
        in_valid <= 1'b0;
        all_sent <= 1'b1;
      end else if (req_q[0].drain_first && (in_valid || owed_r != 0)) begin
        // hold off until every character of earlier requests is out
        in_valid <= 1'b0;
      end else begin
        nxt = req_q.pop_front();
        in_valid <= 1'b1;
        in_value <= nxt.value;
        calm <= (req_q.size() < CALM_ITEMS);
        if (req_q.size() >= CALM_ITEMS && nxt.gappy && $urandom_range(0, 2) == 0)
          gap_left = $urandom_range(1, 9);
      end
    end
  end

  // monitor: predict on accepted requests, check accepted characters, pace out_ready
  always @(posedge clk) begin
    text_char_t exp_c;
    logic       nxt_ready;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      quiet_cycles <= 0;
      owed_r       <= 0;
    end else begin
      if (in_valid && in_ready)
        push_decimal_text(in_value);
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected character: expected none got %h last %b",
                   $time, out_character, out_last);
        end else begin
          exp_c = text_q.pop_front();
          if (out_character !== exp_c.character) begin
            mismatches++;
            $display("%0t: character mismatch: expected %h got %h",
                     $time, exp_c.character, out_character);
          end
          if (out_last !== exp_c.last) begin
            mismatches++;
            $display("%0t: last flag mismatch: expected %b got %b",
                     $time, exp_c.last, out_last);
          end
        end
        if (out_last && $urandom_range(0, 3) == 0)
          stall_mode = !stall_mode;
      end
      owed_r <= text_q.size();

      // watchdog counts cycles with no transfer on either side
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;

      // receiver stall bursts
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!calm && stall_mode && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 8);
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [VALUE_W-1:0] directed[$];
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] lim;
    logic [VALUE_W-1:0] v;
    conv_req_t          rq;
    int                 ndig;
    bit                 gap_seg;
    bit                 timed_out;

    // extremes, zero, minus 2^31, digit-count boundaries
    directed = '{
      64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'hFFFF_FFFF_8000_0000, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
      -64'd9, 64'd999999999999999999, -64'd999999999999999999,
      64'd1000000000000000000, -64'd1000000000000000000, 64'd12345,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
    };
    foreach (directed[i]) begin
      rq.value       = directed[i];
      rq.drain_first = (i == 10);
      rq.gappy       = (i % 3 != 0);
      req_q.push_back(rq);
    end

    gap_seg = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0)
        gap_seg = $urandom_range(0, 1);
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: v = raw;
        3: begin
          // right at or just under a power of ten
          ndig = $urandom_range(0, 18);
          lim = 64'd1;
          repeat (ndig) lim = lim * 64'd10;
          v = lim - $urandom_range(0, 1);
          if ($urandom_range(0, 1)) v = -v;
        end
        default: begin
          ndig = $urandom_range(1, 19);
          lim = 64'd1;
          repeat (ndig) lim = lim * 64'd10;
          v = raw % lim;
          if ($urandom_range(0, 1)) v = -v;
        end
      endcase
      rq.value       = v;
      rq.drain_first = (i == 60) || ($urandom_range(0, 39) == 0);
      rq.gappy       = gap_seg;
      req_q.push_back(rq);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    timed_out = 1'b0;
    while (!(all_sent && owed_r == 0) && !timed_out) begin
      @(posedge clk);
      timed_out = (quiet_cycles >= WATCHDOG_LIMIT);
    end

    if (timed_out) begin
      $display("%0t: watchdog expired with %0d characters owed", $time, owed_r);
      $display("DONE: errors detected");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (mismatches == 0)
        $display("DONE: 0 errors");
      else
        $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
